// ----- hdl/fde_pkg.sv -----
// Shared constants, register codes and interface types for the feedback delay echo
`timescale 1ns / 1ps

package fde_pkg;

  // geometry of the delay lines
  localparam int CHANNELS  = 2;
  localparam int CH_W      = 1;
  localparam int MAX_DELAY = 131072;
  localparam int POS_W     = $clog2(MAX_DELAY);
  localparam int FILL_W    = $clog2(MAX_DELAY + 1);
  localparam int MEM_DEPTH = CHANNELS * MAX_DELAY;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  // field and register widths
  localparam int SAMPLE_W = 24;
  localparam int DELAY_W  = 25;
  localparam int FB_W     = 15;
  localparam int MIX_W    = 16;
  localparam int FRAC_W   = 8;

  // gain and delay limits
  localparam int MAX_FEEDBACK = 31130;
  localparam logic [FB_W-1:0]    FB_LIMIT     = FB_W'(MAX_FEEDBACK);
  localparam logic [MIX_W-1:0]   MIX_UNITY    = 16'h8000;
  localparam logic [DELAY_W-1:0] DELAY_MIN_Q8 = DELAY_W'(256);
  localparam logic [DELAY_W-1:0] DELAY_MAX_Q8 = DELAY_W'((MAX_DELAY - 1) * 256);

  // item operation codes
  localparam logic OP_PROCESS = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  // register map
  localparam int PADDR_W = 4;
  localparam int RIDX_W  = PADDR_W - 2;
  localparam logic [RIDX_W-1:0] REG_ENABLE   = 2'd0;
  localparam logic [RIDX_W-1:0] REG_DELAY    = 2'd1;
  localparam logic [RIDX_W-1:0] REG_FEEDBACK = 2'd2;
  localparam logic [RIDX_W-1:0] REG_MIX      = 2'd3;

  // register reset values
  localparam logic               ENABLE_RST   = 1'b1;
  localparam logic [DELAY_W-1:0] DELAY_RST    = DELAY_W'(6144000);
  localparam logic [FB_W-1:0]    FEEDBACK_RST = '0;
  localparam logic [MIX_W-1:0]   MIX_RST      = MIX_W'(16384);

  typedef struct packed {
    logic               enable;
    logic [DELAY_W-1:0] delay_q8;
    logic [FB_W-1:0]    feedback_q15;
    logic [MIX_W-1:0]   mix_q15;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic rd1;
    logic mac;
    logic mul;
    logic wr;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic process;
    logic out_busy;
  } sts_t;

endpackage

// ----- hdl/fde_regs.sv -----
// Configuration register file behind the APB-style port
`timescale 1ns / 1ps

module fde_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fde_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output fde_pkg::cfg_t                cfg
);

  logic                             enable_r;
  logic [fde_pkg::DELAY_W-1:0]      delay_q8_r;
  logic [fde_pkg::FB_W-1:0]         feedback_q15_r;
  logic [fde_pkg::MIX_W-1:0]        mix_q15_r;
  logic [fde_pkg::RIDX_W-1:0]       ridx;
  logic                             wr_en;

  assign ridx   = paddr[fde_pkg::PADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r       <= fde_pkg::ENABLE_RST;
      delay_q8_r     <= fde_pkg::DELAY_RST;
      feedback_q15_r <= fde_pkg::FEEDBACK_RST;
      mix_q15_r      <= fde_pkg::MIX_RST;
    end else if (wr_en) begin
      case (ridx)
        fde_pkg::REG_ENABLE:   enable_r       <= pwdata[0];
        fde_pkg::REG_DELAY:    delay_q8_r     <= pwdata[fde_pkg::DELAY_W-1:0];
        fde_pkg::REG_FEEDBACK: feedback_q15_r <= pwdata[fde_pkg::FB_W-1:0];
        fde_pkg::REG_MIX:      mix_q15_r      <= pwdata[fde_pkg::MIX_W-1:0];
        default: ;
      endcase
    end
  end

  // readback
  always_comb begin
    case (ridx)
      fde_pkg::REG_ENABLE:   prdata = {31'd0, enable_r};
      fde_pkg::REG_DELAY:    prdata = 32'(delay_q8_r);
      fde_pkg::REG_FEEDBACK: prdata = 32'(feedback_q15_r);
      fde_pkg::REG_MIX:      prdata = 32'(mix_q15_r);
      default:               prdata = '0;
    endcase
  end

  assign cfg.enable       = enable_r;
  assign cfg.delay_q8     = delay_q8_r;
  assign cfg.feedback_q15 = feedback_q15_r;
  assign cfg.mix_q15      = mix_q15_r;

endmodule

// ----- hdl/fde_ctrl.sv -----
// Sequencing state machine: accept, two taps read, interpolate, scale, write back
`timescale 1ns / 1ps

module fde_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  fde_pkg::sts_t sts,
  output fde_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD1  = 3'd1;
  localparam logic [2:0] ST_MAC  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_WR   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  // take an item only when idle and the result register can be freed
  assign in_stall = (state_r != ST_IDLE) || sts.out_busy;
  assign accept   = in_valid && !in_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept && sts.process) state_nxt = ST_RD1;
      ST_RD1:  state_nxt = ST_MAC;
      ST_MAC:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_WR;
      ST_WR:   state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath commands
  assign cmd.accept = accept;
  assign cmd.rd1    = (state_r == ST_RD1);
  assign cmd.mac    = (state_r == ST_MAC);
  assign cmd.mul    = (state_r == ST_MUL);
  assign cmd.wr     = (state_r == ST_WR);

endmodule

// ----- hdl/fde_dp.sv -----
// Datapath: delay line memory, write positions, interpolation, gains and result register
`timescale 1ns / 1ps

module fde_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  fde_pkg::cfg_t                        cfg,
  input  fde_pkg::cmd_t                        cmd,
  output fde_pkg::sts_t                        sts,
  input  logic                                 in_op,
  input  logic [fde_pkg::CH_W-1:0]             in_channel,
  input  logic signed [fde_pkg::SAMPLE_W-1:0]  in_sample_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [fde_pkg::SAMPLE_W-1:0]  out_sample_out,
  output logic [fde_pkg::CH_W-1:0]             out_channel_out
);

  localparam int POS_W  = fde_pkg::POS_W;
  localparam int FILL_W = fde_pkg::FILL_W;
  localparam int SW     = fde_pkg::SAMPLE_W;

  // position of the sample written 'ago' items before the write position
  function automatic logic [POS_W-1:0] tap_pos(input logic [POS_W-1:0] wp,
                                               input logic [POS_W:0]   ago);
    logic [POS_W:0] wpx;
    wpx = {1'b0, wp};
    if (wpx >= ago) return POS_W'(wpx - ago);
    return POS_W'(wpx + (POS_W + 1)'(fde_pkg::MAX_DELAY) - ago);
  endfunction

  function automatic logic [fde_pkg::MEM_AW-1:0] mem_addr(
      input logic [fde_pkg::CH_W-1:0] ch, input logic [POS_W-1:0] pos);
    return fde_pkg::MEM_AW'(ch) * fde_pkg::MEM_AW'(fde_pkg::MAX_DELAY)
         + fde_pkg::MEM_AW'(pos);
  endfunction

  function automatic logic [SW-1:0] sat24(input logic signed [47:0] v);
    if (v > 48'sd8388607)  return 24'h7FFFFF;
    if (v < -48'sd8388608) return 24'h800000;
    return v[SW-1:0];
  endfunction

  // delay line storage
  logic [SW-1:0] delay_mem [fde_pkg::MEM_DEPTH];

  // per-channel write position and fill count
  logic [POS_W-1:0]  wp_r    [fde_pkg::CHANNELS];
  logic [POS_W-1:0]  wp_nxt  [fde_pkg::CHANNELS];
  logic [FILL_W-1:0] fill_r  [fde_pkg::CHANNELS];
  logic [FILL_W-1:0] fill_nxt[fde_pkg::CHANNELS];

  // item registers
  logic [fde_pkg::CH_W-1:0]         ch_r;
  logic signed [SW-1:0]             dry_r;
  logic [fde_pkg::FRAC_W-1:0]       f_r;
  logic                             v0_r;
  logic                             v1_r;
  logic [SW-1:0]                    rdata_r;
  logic signed [SW-1:0]             x0_r;
  logic signed [34:0]               acc_r;
  logic signed [39:0]               pfb_r;
  logic signed [40:0]               pdry_r;
  logic signed [40:0]               pwet_r;

  // result register
  logic                             out_valid_r;
  logic                             out_valid_nxt;
  logic [SW-1:0]                    out_sample_r;
  logic [fde_pkg::CH_W-1:0]         out_ch_r;

  // clamped settings
  logic [fde_pkg::DELAY_W-1:0]      d_clamp;
  logic [POS_W-1:0]                 k;
  logic [POS_W:0]                   ago0;
  logic [POS_W:0]                   ago1;
  logic [fde_pkg::FB_W-1:0]         fb_clamp;
  logic [fde_pkg::MIX_W-1:0]        mix_clamp;

  // item decode
  logic                             ch_ok;
  logic                             is_process;
  logic                             pass_load;
  logic                             clear_go;
  logic                             rd_en;
  logic [fde_pkg::MEM_AW-1:0]       rd_addr;
  logic [fde_pkg::MEM_AW-1:0]       wr_addr;

  // arithmetic
  logic signed [SW-1:0]             x1;
  logic signed [9:0]                w0;
  logic signed [9:0]                w1;
  logic signed [34:0]               p0;
  logic signed [34:0]               p1;
  logic signed [34:0]               acc_rnd;
  logic signed [SW-1:0]             delayed;
  logic signed [15:0]               fb_s;
  logic signed [16:0]               mix_s;
  logic signed [16:0]               dry_w;
  logic signed [39:0]               pfb;
  logic signed [40:0]               pdry;
  logic signed [40:0]               pwet;
  logic signed [39:0]               pfb_rnd;
  logic signed [24:0]               fb_term;
  logic signed [25:0]               stored_full;
  logic signed [41:0]               mix_sum;
  logic signed [26:0]               out_full;
  logic [SW-1:0]                    stored;
  logic [SW-1:0]                    mixed;

  // settings clamp
  always_comb begin
    if (cfg.delay_q8 < fde_pkg::DELAY_MIN_Q8)      d_clamp = fde_pkg::DELAY_MIN_Q8;
    else if (cfg.delay_q8 > fde_pkg::DELAY_MAX_Q8) d_clamp = fde_pkg::DELAY_MAX_Q8;
    else                                           d_clamp = cfg.delay_q8;
  end

  assign k         = POS_W'(d_clamp >> fde_pkg::FRAC_W);
  assign ago0      = {1'b0, k};
  assign ago1      = ago0 + 1'b1;
  assign fb_clamp  = (cfg.feedback_q15 > fde_pkg::FB_LIMIT) ? fde_pkg::FB_LIMIT
                                                            : cfg.feedback_q15;
  assign mix_clamp = (cfg.mix_q15 > fde_pkg::MIX_UNITY) ? fde_pkg::MIX_UNITY : cfg.mix_q15;

  // item decode
  assign ch_ok      = 32'(in_channel) < 32'(fde_pkg::CHANNELS);
  assign is_process = (in_op == fde_pkg::OP_PROCESS) && cfg.enable && ch_ok;
  assign pass_load  = cmd.accept && (in_op == fde_pkg::OP_PROCESS) && !is_process;
  assign clear_go   = cmd.accept && (in_op == fde_pkg::OP_CLEAR);

  assign sts.process  = is_process;
  assign sts.out_busy = out_valid_r && out_stall;

  // memory port addresses: nearer tap on accept, farther tap in the following cycle (RD1)
  assign rd_en   = (cmd.accept && is_process) || cmd.rd1;
  assign rd_addr = cmd.rd1 ? mem_addr(ch_r, tap_pos(wp_r[ch_r], ago1))
                           : mem_addr(in_channel, tap_pos(wp_r[in_channel], ago0));
  assign wr_addr = mem_addr(ch_r, wp_r[ch_r]);

  always_ff @(posedge clk) begin
    if (cmd.wr) delay_mem[wr_addr] <= stored;
    if (rd_en)  rdata_r <= delay_mem[rd_addr];
  end

  // interpolation between the two taps
  assign x1 = v1_r ? signed'(rdata_r) : '0;
  assign w0 = signed'({1'b0, 9'(9'd256 - {1'b0, f_r})});
  assign w1 = signed'({2'b00, f_r});
  assign p0 = x0_r * w0;
  assign p1 = x1 * w1;

  // rounded delayed sample, then feedback and mix products
  assign acc_rnd = acc_r + 35'sd128;
  assign delayed = acc_rnd[31:8];
  assign fb_s    = signed'({1'b0, fb_clamp});
  assign mix_s   = signed'({1'b0, mix_clamp});
  assign dry_w   = signed'({1'b0, 16'(17'h08000 - {1'b0, mix_clamp})});
  assign pfb     = delayed * fb_s;
  assign pdry    = dry_r * dry_w;
  assign pwet    = delayed * mix_s;

  // write-back value and mixed output
  assign pfb_rnd     = pfb_r + 40'sd16384;
  assign fb_term     = pfb_rnd[39:15];
  assign stored_full = dry_r + fb_term;
  assign mix_sum     = pdry_r + pwet_r + 42'sd16384;
  assign out_full    = mix_sum[41:15];
  assign stored      = sat24(48'(stored_full));
  assign mixed       = sat24(48'(out_full));

  // pipeline payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch_r  <= in_channel;
      dry_r <= in_sample_in;
      f_r   <= d_clamp[fde_pkg::FRAC_W-1:0];
      v0_r  <= FILL_W'(ago0) <= fill_r[in_channel];
    end
    if (cmd.rd1) begin
      x0_r <= v0_r ? signed'(rdata_r) : '0;
      v1_r <= FILL_W'(ago1) <= fill_r[ch_r];
    end
    if (cmd.mac) acc_r <= p0 + p1;
    if (cmd.mul) begin
      pfb_r  <= pfb;
      pdry_r <= pdry;
      pwet_r <= pwet;
    end
  end

  // write positions and fill counts
  always_comb begin
    for (int c = 0; c < fde_pkg::CHANNELS; c++) begin
      wp_nxt[c]   = wp_r[c];
      fill_nxt[c] = fill_r[c];
      if (clear_go) begin
        wp_nxt[c]   = '0;
        fill_nxt[c] = '0;
      end else if (cmd.wr && (32'(ch_r) == c)) begin
        wp_nxt[c] = (32'(wp_r[c]) == fde_pkg::MAX_DELAY - 1) ? '0 : wp_r[c] + 1'b1;
        if (32'(fill_r[c]) != fde_pkg::MAX_DELAY) fill_nxt[c] = fill_r[c] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < fde_pkg::CHANNELS; c++) begin
        wp_r[c]   <= '0;
        fill_r[c] <= '0;
      end
    end else begin
      for (int c = 0; c < fde_pkg::CHANNELS; c++) begin
        wp_r[c]   <= wp_nxt[c];
        fill_r[c] <= fill_nxt[c];
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (pass_load || cmd.wr) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pass_load) begin
      out_sample_r <= in_sample_in;
      out_ch_r     <= in_channel;
    end else if (cmd.wr) begin
      out_sample_r <= mixed;
      out_ch_r     <= ch_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sample_out  = signed'(out_sample_r);
  assign out_channel_out = out_ch_r;

endmodule

// ----- hdl/feedback_delay_echo.sv -----
// Top level of the per-channel feedback delay echo
`timescale 1ns / 1ps

// Per-channel echo with a fractional, linearly interpolated delay of up to 131071 samples
// on each of two channels, kept in one single-port-style memory of 262144 x 24 bits. A
// process transfer occupies the block from its accept through states RD1, MAC, MUL and WR:
// the accept reads the nearer tap, RD1 reads the farther tap, MAC does the interpolation
// multiply, MUL the feedback and mix multiplies, and WR writes back and also loads the
// result register; the two reads and one write on the delay memory and the two multiplier
// stages set this sequence. Clear and pass-through transfers (block disabled) finish on
// their accept, and a clear gives no result. The result register holds a finished sample
// while the output is stalled; a new item is taken once that register can drain. The
// memory needs no clearing pass after reset or clear: a per-channel fill count makes
// never-written taps read as zero. Registers: enable at 0x0, delay_q8 at 0x4,
// feedback_q15 at 0x8, mix_q15 at 0xC; write them only while the block is idle.
module feedback_delay_echo (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_op,
  input  logic [fde_pkg::CH_W-1:0]             in_channel,
  input  logic signed [fde_pkg::SAMPLE_W-1:0]  in_sample_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [fde_pkg::SAMPLE_W-1:0]  out_sample_out,
  output logic [fde_pkg::CH_W-1:0]             out_channel_out,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [fde_pkg::PADDR_W-1:0]          paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  fde_pkg::cfg_t cfg;
  fde_pkg::cmd_t cmd;
  fde_pkg::sts_t sts;

  // configuration registers
  fde_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer
  fde_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // delay lines and arithmetic
  fde_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_op),
    .in_channel      (in_channel),
    .in_sample_in    (in_sample_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample_out  (out_sample_out),
    .out_channel_out (out_channel_out)
  );

endmodule

// ----- hdl/fde_checker.sv -----
// Port-level checks for the feedback delay echo, bound to the top level
`timescale 1ns / 1ps

module fde_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 in_op,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [fde_pkg::SAMPLE_W-1:0]  out_sample_out,
  input logic [fde_pkg::CH_W-1:0]             out_channel_out,
  input logic                                 pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_out)
                               && $stable(out_channel_out))
    else $error("stalled result changed");

  // no transfer in while a result sits stalled
  a_no_accept_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !(out_valid && out_stall))
    else $error("input taken while result register blocked");

  // a clear leaves no result behind
  a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op == fde_pkg::OP_CLEAR) |=> !out_valid)
    else $error("clear produced a result");

  // register port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind feedback_delay_echo fde_checker u_fde_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_op           (in_op),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_sample_out  (out_sample_out),
  .out_channel_out (out_channel_out),
  .pready          (pready)
);

// ----- sim/fde_echo_checker.sv -----
// Transfer monitor, echo predictor and result comparison for the feedback delay echo
`timescale 1ns / 1ps

module fde_echo_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic                                 in_op,
  input  logic [fde_pkg::CH_W-1:0]             in_channel,
  input  logic signed [fde_pkg::SAMPLE_W-1:0]  in_sample_in,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [fde_pkg::SAMPLE_W-1:0]  out_sample_out,
  input  logic [fde_pkg::CH_W-1:0]             out_channel_out,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic                                 pready,
  input  logic [fde_pkg::PADDR_W-1:0]          paddr,
  input  logic [31:0]                          pwdata,
  output int                                   err_count,
  output int                                   pending
);
  import fde_pkg::*;

  localparam longint Q8_ONE  = 256;
  localparam longint Q15_ONE = 32768;
  localparam int     Q15_SH  = 15;
  localparam longint S24_HI  = 8388607;
  localparam longint S24_LO  = -8388608;

  typedef struct {
    logic signed [SAMPLE_W-1:0] smp;
    logic [CH_W-1:0]            ch;
  } echo_t;

  echo_t echo_q[$];

  // delay lines, keyed by channel * MAX_DELAY + slot; a missing key reads as zero
  logic signed [SAMPLE_W-1:0] line_mem [int];
  int unsigned                wr_pos [CHANNELS];

  // shadow copy of the registers
  logic               en_r;
  logic [DELAY_W-1:0] dly_r;
  logic [FB_W-1:0]    fb_r;
  logic [MIX_W-1:0]   mix_r;
  int                 n_err = 0;

  initial begin
    err_count = 0;
    pending   = 0;
  end

  // divide by 2^sh, round to nearest, ties toward plus infinity
  function automatic longint rnd_shift(longint v, int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint sat24(longint v);
    if (v > S24_HI) return S24_HI;
    if (v < S24_LO) return S24_LO;
    return v;
  endfunction

  // sample written 'ago' items back on channel ch
  function automatic longint line_tap(int unsigned ch, int unsigned ago);
    int unsigned pos;
    int          key;
    pos = (wr_pos[ch] >= ago) ? wr_pos[ch] - ago : wr_pos[ch] + MAX_DELAY - ago;
    key = int'(ch) * MAX_DELAY + int'(pos);
    if (line_mem.exists(key)) return line_mem[key];
    return 0;
  endfunction

  always @(posedge clk) begin : track
    echo_t       want;
    longint      dry, acc, delayed, res, d, k, f, fbv, mx;
    int unsigned ch;
    int          key;
    if (!rst_n) begin
      en_r  = ENABLE_RST;
      dly_r = DELAY_RST;
      fb_r  = FEEDBACK_RST;
      mix_r = MIX_RST;
      line_mem.delete();
      foreach (wr_pos[i]) wr_pos[i] = 0;
      echo_q.delete();
    end else begin
      // register write
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_ENABLE:   en_r  = pwdata[0];
          REG_DELAY:    dly_r = pwdata[DELAY_W-1:0];
          REG_FEEDBACK: fb_r  = pwdata[FB_W-1:0];
          REG_MIX:      mix_r = pwdata[MIX_W-1:0];
          default: ;
        endcase
      end

      // result transfer against the oldest expectation
      if (out_valid && !out_stall) begin
        if (echo_q.size() == 0) begin
          $error("unexpected result: sample_out %0d channel_out %0d",
                 out_sample_out, out_channel_out);
          n_err++;
        end else begin
          want = echo_q.pop_front();
          if (out_sample_out !== want.smp) begin
            $error("sample_out mismatch: expected %0d, got %0d", want.smp, out_sample_out);
            n_err++;
          end
          if (out_channel_out !== want.ch) begin
            $error("channel_out mismatch: expected %0d, got %0d", want.ch, out_channel_out);
            n_err++;
          end
        end
      end

      // input transfer
      if (in_valid && !in_stall) begin
        dry = in_sample_in;
        ch  = in_channel;
        if (in_op == OP_CLEAR) begin
          line_mem.delete();
          foreach (wr_pos[i]) wr_pos[i] = 0;
        end else begin
          res = dry;
          if (en_r && ch < CHANNELS) begin
            // clamp delay, split into whole and fractional samples
            d = dly_r;
            if (d < DELAY_MIN_Q8) d = DELAY_MIN_Q8;
            if (d > DELAY_MAX_Q8) d = DELAY_MAX_Q8;
            k = d >> FRAC_W;
            f = d % Q8_ONE;
            acc = line_tap(ch, k) * (Q8_ONE - f) + line_tap(ch, k + 1) * f;
            delayed = rnd_shift(acc, FRAC_W);

            // gain clamps
            fbv = fb_r;
            if (fbv > MAX_FEEDBACK) fbv = MAX_FEEDBACK;
            mx = mix_r;
            if (mx > Q15_ONE) mx = Q15_ONE;

            // feedback write into the line
            key = int'(ch) * MAX_DELAY + int'(wr_pos[ch]);
            line_mem[key] = sat24(dry + rnd_shift(delayed * fbv, Q15_SH));
            wr_pos[ch] = (wr_pos[ch] + 1 == MAX_DELAY) ? 0 : wr_pos[ch] + 1;

            // dry/wet crossfade
            res = sat24(rnd_shift(dry * (Q15_ONE - mx) + delayed * mx, Q15_SH));
          end
          want.smp = res[SAMPLE_W-1:0];
          want.ch  = in_channel;
          echo_q.push_back(want);
        end
      end
    end
    pending   <= echo_q.size();
    err_count <= n_err;
  end

endmodule

// ----- sim/tb_feedback_delay_echo.sv -----
// Testbench top for the feedback delay echo: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_feedback_delay_echo;
  import fde_pkg::*;

  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 104;
  localparam int LONG_HOLD       = 100;
  localparam int DRAIN_CYCLES    = 12;
  localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 24'sh800000;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_op = OP_PROCESS;
  logic [CH_W-1:0]            in_channel = '0;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic [CH_W-1:0]            out_channel_out;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [PADDR_W-1:0]         paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;

  int   snd_idle_pct = 14;
  int   rcv_idle_pct = 67;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int   hold_left = 0;
  int   err_count;
  int   pending;

  always #4 clk = ~clk;

  feedback_delay_echo u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_channel      (in_channel),
    .in_sample_in    (in_sample_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample_out  (out_sample_out),
    .out_channel_out (out_channel_out),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  fde_echo_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_channel      (in_channel),
    .in_sample_in    (in_sample_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample_out  (out_sample_out),
    .out_channel_out (out_channel_out),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .err_count       (err_count),
    .pending         (pending)
  );

  // result side: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // one input transfer, with random idle cycles ahead of it
  task automatic send_item(input logic op, input logic [CH_W-1:0] ch,
                           input logic signed [SAMPLE_W-1:0] smp);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_channel   <= ch;
    in_sample_in <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // register write: setup then access cycle
  task automatic cfg_write(input logic [RIDX_W-1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering, wait for every expected result, then let clears finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic                       op;
    logic [CH_W-1:0]            ch;
    logic signed [SAMPLE_W-1:0] smp;
    logic [31:0]                val;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: long delay, no feedback, half mix
    send_item(OP_PROCESS, 1'b0, SMP_MAX);
    send_item(OP_PROCESS, 1'b1, SMP_MIN);
    send_item(OP_PROCESS, 1'b0, 24'sd0);
    send_item(OP_PROCESS, 1'b1, -24'sd1);
    settle();

    // 1.5 sample delay, feedback and mix above their limits, saturation
    cfg_write(REG_DELAY, 32'h180);
    cfg_write(REG_FEEDBACK, 32'h7FFF);
    cfg_write(REG_MIX, 32'hFFFF);
    repeat (3) send_item(OP_PROCESS, 1'b0, SMP_MAX);
    repeat (3) send_item(OP_PROCESS, 1'b1, SMP_MIN);
    send_item(OP_CLEAR, 1'b0, 24'sd0);
    send_item(OP_CLEAR, 1'b1, SMP_MIN);
    send_item(OP_PROCESS, 1'b0, SMP_MAX);
    send_item(OP_PROCESS, 1'b0, SMP_MIN);
    settle();

    // delay above its range, feedback at its limit, all dry
    cfg_write(REG_DELAY, 32'h1FF_FFFF);
    cfg_write(REG_FEEDBACK, MAX_FEEDBACK);
    cfg_write(REG_MIX, 32'h0);
    send_item(OP_PROCESS, 1'b0, 24'sd123456);
    send_item(OP_PROCESS, 1'b1, -24'sd654321);
    settle();

    // disabled: pass-through, clear still allowed
    cfg_write(REG_ENABLE, 32'h0);
    cfg_write(REG_MIX, MIX_UNITY);
    send_item(OP_PROCESS, 1'b0, SMP_MAX);
    send_item(OP_PROCESS, 1'b1, SMP_MIN);
    send_item(OP_CLEAR, 1'b0, 24'sd0);
    send_item(OP_PROCESS, 1'b1, 24'sd42);
    settle();

    // delay below its range
    cfg_write(REG_ENABLE, 32'h1);
    cfg_write(REG_DELAY, 32'h0);
    send_item(OP_PROCESS, 1'b0, SMP_MIN);
    send_item(OP_PROCESS, 1'b1, SMP_MAX);

    // random phases, each with fresh settings
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES / 3) begin
        snd_idle_pct = 67;
        rcv_idle_pct = 14;
      end
      if (ph == 2 * PHASES / 3) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      settle();
      cfg_write(REG_ENABLE, (ph % 6 == 4) ? 32'h0 : 32'h1);
      case ((ph == 0) ? 3 : $urandom_range(7))
        0: val = 32'h0;
        1: val = 32'h100;
        2: val = 32'h1FF_FFFF;
        3: val = DELAY_MAX_Q8;
        default: val = $urandom_range(48 * 256, 256);
      endcase
      cfg_write(REG_DELAY, val);
      case ($urandom_range(4))
        0: val = 32'h0;
        1: val = 32'h7FFF;
        2: val = MAX_FEEDBACK;
        default: val = $urandom_range(32'h7FFF);
      endcase
      cfg_write(REG_FEEDBACK, val);
      case ($urandom_range(4))
        0: val = 32'h0;
        1: val = MIX_UNITY;
        2: val = 32'hFFFF;
        default: val = $urandom_range(32768);
      endcase
      cfg_write(REG_MIX, val);

      // long receiver hold-off while the sender keeps going
      if (ph == 1) hold_req <= ~hold_req;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        op = ($urandom_range(99) == 0) ? OP_CLEAR : OP_PROCESS;
        ch = $urandom_range(CHANNELS - 1);
        case ($urandom_range(9))
          0: smp = SMP_MAX;
          1: smp = SMP_MIN;
          2: smp = $urandom_range(512) - 256;
          default: smp = $urandom;
        endcase
        send_item(op, ch, smp);
      end
    end

    settle();
    if (err_count == 0 && pending == 0) begin
      $display("tb_feedback_delay_echo passed");
    end else begin
      $display("tb_feedback_delay_echo failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("tb_feedback_delay_echo failed");
    $finish;
  end

endmodule
